// ===== rtl/core/svwf_pkg.sv =====
// Shared types and constants for the switched whitening filter.
// No dependencies; every other file in rtl/core except svwf_ram uses this package.
`timescale 1ns / 1ps

package svwf_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_W     = 16;
  localparam int ADDR_W       = 7;
  localparam int CFG_W        = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_ROW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [ADDR_W-1:0]            addr;
    sample_t                      value;
    logic                         stim;
    logic                         emit;
    sample_t [MAX_CHANNELS-1:0]   sample;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

endpackage

// ===== rtl/core/switched_var_whitening_filter_top.sv =====
// Switched vector autoregressive whitening filter, top level.
// Depends on svwf_pkg, svwf_front, svwf_fifo, svwf_back and svwf_ram.
//
// Input channel (in_valid / in_stall): each request either loads one coefficient
// word (op = 0) or presents one time row of samples (op = 1). Output channel
// (out_valid / out_stall): one whitened row for every presented row whose emit
// flag is set. Loads and rows without emit give no output, but rows without
// emit still enter the history. The lag_count register is written through
// cfg_write_en / cfg_write_data by the user only while the block is idle; the
// block itself does not enforce this. A single shared multiplier walks every
// product in turn against the coefficient RAM's one read port, so the back part
// takes no new command until it has finished the current row. A two-entry
// command queue lets the front keep taking requests meanwhile.
// Reset (rst, synchronous, active high) clears the row history, the lag count
// and all handshake state; coefficients must be loaded before use.
// While out_stall holds a result, the back part waits to retire the next
// emitting row; the queue then fills and in_stall rises.
`timescale 1ns / 1ps

module switched_var_whitening_filter_top #(
  parameter int CHANNELS = 4,
  parameter int LAGS     = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [svwf_pkg::CFG_W-1:0]          cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [svwf_pkg::ADDR_W-1:0]         coef_addr,
  input  svwf_pkg::sample_t                   coef_value,
  input  logic                                stim,
  input  logic                                emit,
  input  svwf_pkg::sample_t                   sample_0,
  input  svwf_pkg::sample_t                   sample_1,
  input  svwf_pkg::sample_t                   sample_2,
  input  svwf_pkg::sample_t                   sample_3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output svwf_pkg::sample_t                   white_0,
  output svwf_pkg::sample_t                   white_1,
  output svwf_pkg::sample_t                   white_2,
  output svwf_pkg::sample_t                   white_3,
  output logic                                saturated
);
  import svwf_pkg::*;

  // Coefficient store holds both sets: stimulus first, then baseline.
  localparam int COEF_DEPTH = 2 * LAGS * CHANNELS * CHANNELS;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  logic [CFG_W-1:0] lag_count;

  logic  q_push, q_full, q_pop, q_empty;
  cmd_t  q_cmd, q_head;

  logic                ram_we;
  logic [COEF_AW-1:0]  ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  sample_t [MAX_CHANNELS-1:0] white;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lag_count <= '0;
    end else if (cfg_write_en) begin
      lag_count <= cfg_write_data;
    end
  end

  svwf_front #(
    .COEF_DEPTH (COEF_DEPTH)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .coef_addr  (coef_addr),
    .coef_value (coef_value),
    .stim       (stim),
    .emit       (emit),
    .sample_0   (sample_0),
    .sample_1   (sample_1),
    .sample_2   (sample_2),
    .sample_3   (sample_3),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  svwf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  svwf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (COEF_DEPTH),
    .AW    (COEF_AW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  svwf_back #(
    .CHANNELS   (CHANNELS),
    .LAGS       (LAGS),
    .COEF_AW    (COEF_AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .lag_count     (lag_count),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_white     (white),
    .out_saturated (saturated)
  );

  assign white_0 = white[0];
  assign white_1 = white[1];
  assign white_2 = white[2];
  assign white_3 = white[3];

endmodule

// ===== rtl/core/svwf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module svwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/svwf_fifo.sv =====
// Short command queue between the front and back parts of the filter.
// Depends on svwf_pkg for the command type and queue depth.
`timescale 1ns / 1ps

module svwf_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  svwf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output svwf_pkg::cmd_t head,
  output logic           empty
);
  import svwf_pkg::*;

  cmd_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/svwf_front.sv =====
// Front part: accepts requests, classifies them and queues commands.
// Depends on svwf_pkg; out-of-range coefficient loads are dropped here.
`timescale 1ns / 1ps

module svwf_front #(
  parameter int COEF_DEPTH = 128
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [svwf_pkg::ADDR_W-1:0]   coef_addr,
  input  svwf_pkg::sample_t             coef_value,
  input  logic                          stim,
  input  logic                          emit,
  input  svwf_pkg::sample_t             sample_0,
  input  svwf_pkg::sample_t             sample_1,
  input  svwf_pkg::sample_t             sample_2,
  input  svwf_pkg::sample_t             sample_3,
  input  logic                          q_full,
  output logic                          q_push,
  output svwf_pkg::cmd_t                q_cmd
);
  import svwf_pkg::*;

  logic accept;
  logic in_range;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = (32'(coef_addr) < COEF_DEPTH);

  // A row always goes on; a load goes on only if its address exists.
  assign q_push = accept && (op || in_range);

  always_comb begin
    q_cmd.kind      = op ? CMD_ROW : CMD_LOAD;
    q_cmd.addr      = coef_addr;
    q_cmd.value     = coef_value;
    q_cmd.stim      = stim;
    q_cmd.emit      = emit;
    q_cmd.sample[0] = sample_0;
    q_cmd.sample[1] = sample_1;
    q_cmd.sample[2] = sample_2;
    q_cmd.sample[3] = sample_3;
  end

endmodule

// ===== rtl/core/svwf_back.sv =====
// Back part: coefficient writes, the shared multiply-accumulate sequence,
// the row history and the output register. Depends on svwf_pkg.
`timescale 1ns / 1ps

module svwf_back #(
  parameter int CHANNELS   = 4,
  parameter int LAGS       = 4,
  parameter int COEF_AW    = 7
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [svwf_pkg::CFG_W-1:0]                lag_count,
  input  logic                                      q_empty,
  input  svwf_pkg::cmd_t                            q_head,
  output logic                                      q_pop,
  output logic                                      ram_we,
  output logic [COEF_AW-1:0]                        ram_waddr,
  output logic [svwf_pkg::SAMPLE_W-1:0]             ram_wdata,
  output logic [COEF_AW-1:0]                        ram_raddr,
  input  logic [svwf_pkg::SAMPLE_W-1:0]             ram_rdata,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output svwf_pkg::sample_t [svwf_pkg::MAX_CHANNELS-1:0] out_white,
  output logic                                      out_saturated
);
  import svwf_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW    = (LAGS > 1) ? $clog2(LAGS) : 1;
  localparam int LCW   = $clog2(LAGS + 1);
  localparam int ACC_W = 2 * SAMPLE_W + $clog2(LAGS * CHANNELS + 1) + 1;
  localparam int FRAC  = 14;

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1 << (FRAC - 1));
  localparam logic signed [ACC_W-1:0] MAX_POS = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN_NEG = -ACC_W'(32768);

  back_state_t state, state_next;

  cmd_t        cur;
  logic [CW-1:0] pc, qc;
  logic [LW-1:0] lc;
  logic [LCW-1:0] lags_eff;
  logic [LW-1:0]  lag_last;
  logic           issue;
  logic           fire;
  logic           out_free;
  logic           run_done;

  sample_t       hist [LAGS][CHANNELS];
  logic [LAGS-1:0] stim_hist;
  sample_t       white [CHANNELS];
  sample_t [MAX_CHANNELS-1:0] white_pad;
  logic          sat;

  // Multiply-accumulate pipeline: issue, product, accumulate, round.
  logic          s1_valid, s2_valid, s3_valid;
  sample_t       s1_sample;
  logic          s1_first, s1_last, s2_first, s2_last;
  logic [CW-1:0] s1_ch, s2_ch, s3_ch;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [ACC_W-1:0]      acc, acc_in, prod_ext, rsum, rq;
  sample_t                      sat_val;
  logic                         clip;
  int                           idx;

  assign lags_eff = (32'(lag_count) > LAGS) ? LCW'(LAGS) : LCW'(lag_count);
  assign lag_last = LW'(lags_eff - 1'b1);
  assign out_free = !out_valid || !out_stall;
  assign run_done = (pc == CW'(CHANNELS - 1)) && (lc == lag_last) &&
                    (qc == CW'(CHANNELS - 1));

  always_comb begin
    idx = ((int'(!stim_hist[lc]) * LAGS + int'(lc)) * CHANNELS + int'(qc)) * CHANNELS
          + int'(pc);
  end

  assign ram_raddr = COEF_AW'(idx);
  assign ram_waddr = COEF_AW'(q_head.addr);
  assign ram_wdata = q_head.value;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && q_head.kind == CMD_ROW) begin
          if (q_head.emit && lags_eff != '0) begin
            state_next = ST_RUN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid && !s3_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!cur.emit || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop  = 1'b0;
    ram_we = 1'b0;
    issue  = 1'b0;
    fire   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop  = !q_empty;
        ram_we = !q_empty && (q_head.kind == CMD_LOAD);
      end
      ST_RUN:    issue = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: fire = !cur.emit || out_free;
      default:   ;
    endcase
  end

  // Accumulate and round.
  always_comb begin
    prod_ext = ACC_W'(prod);
    acc_in   = s2_first ? (ACC_W'($signed(cur.sample[s2_ch])) <<< FRAC) : acc;
    rsum     = acc + HALF;
    rq       = rsum >>> FRAC;
    clip     = 1'b0;
    if (rq > MAX_POS) begin
      sat_val = sample_t'(MAX_POS);
      clip    = 1'b1;
    end else if (rq < MIN_NEG) begin
      sat_val = sample_t'(MIN_NEG);
      clip    = 1'b1;
    end else begin
      sat_val = sample_t'(rq);
    end
  end

  // Channels beyond CHANNELS always read zero.
  always_comb begin
    white_pad = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      white_pad[c] = white[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      stim_hist <= '0;
      for (int l = 0; l < LAGS; l++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          hist[l][c] <= '0;
        end
      end
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_last;
      if (fire && cur.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        for (int l = LAGS - 1; l > 0; l--) begin
          for (int c = 0; c < CHANNELS; c++) begin
            hist[l][c] <= hist[l-1][c];
          end
        end
        for (int c = 0; c < CHANNELS; c++) begin
          hist[0][c] <= cur.sample[c];
        end
        stim_hist <= LAGS'({stim_hist, cur.stim});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == CMD_ROW) begin
      cur <= q_head;
      pc  <= '0;
      lc  <= '0;
      qc  <= '0;
      sat <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        white[c] <= q_head.sample[c];
      end
    end
    if (issue) begin
      s1_sample <= hist[lc][qc];
      s1_first  <= (lc == '0) && (qc == '0);
      s1_last   <= (lc == lag_last) && (qc == CW'(CHANNELS - 1));
      s1_ch     <= pc;
      if (qc == CW'(CHANNELS - 1)) begin
        qc <= '0;
        if (lc == lag_last) begin
          lc <= '0;
          pc <= pc + 1'b1;
        end else begin
          lc <= lc + 1'b1;
        end
      end else begin
        qc <= qc + 1'b1;
      end
    end
    prod     <= s1_sample * $signed(ram_rdata);
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_ch    <= s1_ch;
    if (s2_valid) begin
      acc   <= acc_in - prod_ext;
      s3_ch <= s2_ch;
    end
    if (s3_valid) begin
      white[s3_ch] <= sat_val;
      if (clip) begin
        sat <= 1'b1;
      end
    end
    if (fire && cur.emit) begin
      out_white     <= white_pad;
      out_saturated <= sat;
    end
  end

endmodule
